>>> design/mosl_pkg.sv
package mosl_pkg;

    localparam int LIST_DEPTH = 1024;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int TOT_W      = $clog2(2 * LIST_DEPTH + 1);
    localparam int VAL_W      = 32;

    localparam logic [1:0] ACT_FIRST  = 2'd0;
    localparam logic [1:0] ACT_SECOND = 2'd1;
    localparam logic [1:0] ACT_MEDIAN = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W:0] median_times_two;
        logic                  empty_flag;
        logic                  overflow_flag;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_b;
    } t_walk_cmd;

    typedef struct packed {
        logic                  done;
        logic signed [VAL_W:0] median2;
        logic                  empty;
    } t_walk_rsp;

endpackage

>>> design/median_of_two_sorted_lists.sv
// Median of two sorted lists. Appends (action 0 or 1) each write
// i_in.value at the end of the named list; an append to a full list is
// dropped and remembered for the overflow flag. A compute (action 2) walks
// both lists in merge order, one element per cycle through the read ports of
// the two list memories, and returns twice the median on o_out for exactly
// one cycle with o_valid high; it then empties both lists. The receiver cannot
// stall: sample o_out whenever o_valid is high. A compute keeps busy high
// until its result has gone out on o_out, and no transfer is taken while
// busy is high. Action 3 is accepted and ignored.
module median_of_two_sorted_lists import mosl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_in,
    output logic busy,
    output logic o_valid,
    output t_out o_out
);

    logic [CNT_W-1:0] r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0] r_cnt_b, n_cnt_b;
    logic             r_drop, n_drop;
    logic             r_busy, n_busy;

    logic             w_accept;
    logic             w_full_a;
    logic             w_full_b;
    logic             w_wr_a;
    logic             w_wr_b;

    logic [ADDR_W-1:0]       w_addr_a;
    logic [ADDR_W-1:0]       w_addr_b;
    logic [VAL_W-1:0]        w_rd_a;
    logic [VAL_W-1:0]        w_rd_b;
    t_walk_cmd               w_cmd;
    t_walk_rsp               w_rsp;

    assign w_accept = start && !r_busy;
    assign w_full_a = (r_cnt_a >= CNT_W'(LIST_DEPTH));
    assign w_full_b = (r_cnt_b >= CNT_W'(LIST_DEPTH));
    assign w_wr_a   = w_accept && (i_in.action == ACT_FIRST) && !w_full_a;
    assign w_wr_b   = w_accept && (i_in.action == ACT_SECOND) && !w_full_b;

    // List memories. Writes happen only while no compute runs (busy blocks
    // appends), so no read used by the walk meets a write to the same entry.
    mosl_ram #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (VAL_W)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_a),
        .i_wr_addr (r_cnt_a[ADDR_W-1:0]),
        .i_wr_data (i_in.value),
        .i_rd_addr (w_addr_a),
        .o_rd_data (w_rd_a)
    );

    mosl_ram #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (VAL_W)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_b),
        .i_wr_addr (r_cnt_b[ADDR_W-1:0]),
        .i_wr_data (i_in.value),
        .i_rd_addr (w_addr_b),
        .o_rd_data (w_rd_b)
    );

    assign w_cmd.start = w_accept && (i_in.action == ACT_MEDIAN);
    assign w_cmd.cnt_a = r_cnt_a;
    assign w_cmd.cnt_b = r_cnt_b;

    mosl_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_rd_a   ($signed(w_rd_a)),
        .i_rd_b   ($signed(w_rd_b)),
        .o_addr_a (w_addr_a),
        .o_addr_b (w_addr_b),
        .o_rsp    (w_rsp)
    );

    always_comb begin
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_drop  = r_drop;
        n_busy  = r_busy;
        if (w_accept) begin
            case (i_in.action)
                ACT_FIRST: begin
                    if (w_full_a) begin
                        n_drop = 1'b1;
                    end else begin
                        n_cnt_a = r_cnt_a + CNT_W'(1);
                    end
                end
                ACT_SECOND: begin
                    if (w_full_b) begin
                        n_drop = 1'b1;
                    end else begin
                        n_cnt_b = r_cnt_b + CNT_W'(1);
                    end
                end
                ACT_MEDIAN: begin
                    n_busy = 1'b1;
                end
                default: begin
                end
            endcase
        end
        // result goes out this cycle: empty both lists and drop the mark
        if (w_rsp.done) begin
            n_cnt_a = '0;
            n_cnt_b = '0;
            n_drop  = 1'b0;
            n_busy  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_drop  <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_drop  <= n_drop;
            r_busy  <= n_busy;
        end
    end

    assign busy                   = r_busy;
    assign o_valid                = w_rsp.done;
    assign o_out.median_times_two = w_rsp.median2;
    assign o_out.empty_flag       = w_rsp.empty;
    assign o_out.overflow_flag    = r_drop;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result transfer outside a compute");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_in.action == ACT_MEDIAN)) |=> busy)
        else $error("compute accepted without raising busy");

    a_busy_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_valid))
        else $error("busy dropped without a result transfer");

endmodule

>>> design/mosl_ram.sv
module mosl_ram #(
    parameter int  DEPTH = 1024,
    parameter int  WIDTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/mosl_walk.sv
module mosl_walk import mosl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_walk_cmd               i_cmd,
    input  logic signed [VAL_W-1:0] i_rd_a,
    input  logic signed [VAL_W-1:0] i_rd_b,
    output logic [ADDR_W-1:0]       o_addr_a,
    output logic [ADDR_W-1:0]       o_addr_b,
    output t_walk_rsp               o_rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_STEP = 1'b1;

    logic                    r_state, n_state;
    logic [CNT_W-1:0]        r_i, n_i;
    logic [CNT_W-1:0]        r_j, n_j;
    logic [TOT_W-1:0]        r_p, n_p;
    logic signed [VAL_W-1:0] r_lo, n_lo;
    logic                    r_done, n_done;
    logic signed [VAL_W:0]   r_med, n_med;
    logic                    r_empty, n_empty;

    logic [TOT_W-1:0]        w_total;
    logic [TOT_W-1:0]        w_mid;
    logic [TOT_W-1:0]        w_p_inc;
    logic                    w_take_a;
    logic signed [VAL_W-1:0] w_v;

    assign w_total  = TOT_W'(i_cmd.cnt_a) + TOT_W'(i_cmd.cnt_b);
    assign w_mid    = w_total >> 1;
    assign w_p_inc  = r_p + TOT_W'(1);
    // take the head of the first list on ties
    assign w_take_a = (r_i < i_cmd.cnt_a) &&
                      ((r_j >= i_cmd.cnt_b) || (i_rd_a <= i_rd_b));
    assign w_v      = w_take_a ? i_rd_a : i_rd_b;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_p     = r_p;
        n_lo    = r_lo;
        n_done  = 1'b0;
        n_med   = r_med;
        n_empty = r_empty;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    if (w_total == '0) begin
                        n_done  = 1'b1;
                        n_med   = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_state = S_STEP;
                        n_i     = '0;
                        n_j     = '0;
                        n_p     = '0;
                    end
                end
            end
            S_STEP: begin
                if (w_take_a) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
                if (w_p_inc == w_mid) begin
                    n_lo = w_v;
                end
                if (r_p == w_mid) begin
                    n_done  = 1'b1;
                    n_empty = 1'b0;
                    n_state = S_IDLE;
                    if (w_total[0]) begin
                        n_med = {w_v[VAL_W-1], w_v} + {w_v[VAL_W-1], w_v};
                    end else begin
                        n_med = {r_lo[VAL_W-1], r_lo} + {w_v[VAL_W-1], w_v};
                    end
                end else begin
                    n_p = w_p_inc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_p     <= n_p;
        r_lo    <= n_lo;
        r_med   <= n_med;
        r_empty <= n_empty;
    end

    // present the next heads so their data lands in the following cycle
    assign o_addr_a = n_i[ADDR_W-1:0];
    assign o_addr_b = n_j[ADDR_W-1:0];

    assign o_rsp.done    = r_done;
    assign o_rsp.median2 = r_med;
    assign o_rsp.empty   = r_empty;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_p <= w_mid))
        else $error("merge step ran past the middle");

    a_step_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> ((TOT_W'(r_i) + TOT_W'(r_j)) == r_p))
        else $error("merge pointers out of step with position");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for more than one cycle");

endmodule
